>>> design/rrsd_pkg.sv
// ----------------------------------------------------------------------------
// rrsd_pkg
// shared constants and types of the run-length raster span decoder
// ----------------------------------------------------------------------------
package rrsd_pkg;

    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;

    localparam int BYTE_W   = 8;
    localparam int ROW_W    = 9;
    localparam int COL_W    = 10;
    localparam int LEN_W    = 7;
    localparam int COLOR_W  = 7;

    localparam int OUT_PAY_W   = ROW_W + COL_W + LEN_W + COLOR_W;
    localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_PAY_W;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [LEN_W-1:0]   length;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               done;
    } t_span;

    typedef struct packed {
        logic [1:0] count;
        t_span      span0;
        t_span      span1;
    } t_push;

endpackage

>>> design/rrsd_decode.sv
// ----------------------------------------------------------------------------
// rrsd_decode
// input register, token state and span split for one stream byte
// ----------------------------------------------------------------------------
module rrsd_decode import rrsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,    // stream_byte
    input  logic [CNT_W-1:0]  i_fifo_count,
    output t_push             o_push
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_await;
    logic [LEN_W-1:0]  r_pending;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_done;

    logic               advance;
    logic               run_start;
    logic               emit;
    logic [LEN_W-1:0]   run_len;
    logic [COLOR_W-1:0] run_color;
    logic [COL_W-1:0]   room;
    logic [LEN_W-1:0]   take1;
    logic [COL_W:0]     col_sum;
    logic               wrap;
    logic [ROW_W-1:0]   row_inc;
    logic               hit_end;
    logic [LEN_W-1:0]   rest;
    logic               second;

    assign advance    = r_in_valid && (i_fifo_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_s_tready = !r_in_valid || advance;

    always_comb begin
        run_start = !r_done && (r_await || r_in_byte[BYTE_W-1]);
        run_len   = r_await ? r_pending : LEN_W'(1);
        run_color = r_in_byte[COLOR_W-1:0];
        emit      = advance && run_start && (run_len != '0);
        room      = COL_W'(IMAGE_WIDTH) - r_col;
        take1     = ({{(COL_W-LEN_W){1'b0}}, run_len} < room) ? run_len : room[LEN_W-1:0];
        col_sum   = {1'b0, r_col} + (COL_W+1)'(take1);
        wrap      = col_sum >= (COL_W+1)'(IMAGE_WIDTH);
        row_inc   = r_row + ROW_W'(1);
        hit_end   = wrap && (row_inc >= ROW_W'(IMAGE_HEIGHT));
        rest      = run_len - take1;
        second    = wrap && !hit_end && (rest != '0);

        o_push.span0.row    = r_row;
        o_push.span0.column = r_col;
        o_push.span0.length = take1;
        o_push.span0.color  = run_color;
        o_push.span0.last   = !second;
        o_push.span0.done   = hit_end;

        o_push.span1.row    = row_inc;
        o_push.span1.column = '0;
        o_push.span1.length = rest;
        o_push.span1.color  = run_color;
        o_push.span1.last   = 1'b1;
        o_push.span1.done   = 1'b0;

        o_push.count = emit ? (second ? 2'd2 : 2'd1) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_await    <= 1'b0;
            r_pending  <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_done     <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance && !r_done) begin
                if (r_await) begin
                    r_await <= 1'b0;
                end else if (!r_in_byte[BYTE_W-1]) begin
                    r_pending <= r_in_byte[LEN_W-1:0];
                    r_await   <= 1'b1;
                end
            end
            if (emit) begin
                if (wrap) begin
                    r_row  <= row_inc;
                    r_col  <= second ? COL_W'(rest) : '0;
                    r_done <= hit_end;
                end else begin
                    r_col <= col_sum[COL_W-1:0];
                end
            end
        end
    end

    a_quiet_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (o_push.count == 2'd0))
        else $error("span pushed after frame end");

    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (o_push.span1.last && !o_push.span0.last
                                    && !o_push.span0.done))
        else $error("bad flags on split run");

    a_nonzero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count != 2'd0) |-> (o_push.span0.length != '0))
        else $error("empty span pushed");

endmodule

>>> design/rrsd_span_fifo.sv
// ----------------------------------------------------------------------------
// rrsd_span_fifo
// small span queue taking up to two spans per cycle, one out per transfer
// ----------------------------------------------------------------------------
module rrsd_span_fifo import rrsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    output logic [CNT_W-1:0] o_count,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output t_span            o_span
);

    t_span            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign o_count    = r_count;
    assign o_m_tvalid = r_count != '0;
    assign o_span     = r_mem[r_rd_ptr];
    assign pop        = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.span0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_push.span1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(i_push.count) - CNT_W'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("span queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((CNT_W+1)'(r_count) + (CNT_W+1)'(i_push.count)) <= (CNT_W+1)'(FIFO_DEPTH))
        else $error("span queue overflow");

endmodule

>>> design/rle_raster_span_decoder.sv
// ----------------------------------------------------------------------------
// rle_raster_span_decoder
// decodes a run-length packed byte stream into raster spans
// ----------------------------------------------------------------------------
// slave channel: one stream byte per transfer on s_tdata
// master channel: one span per transfer; tdata holds row, column, length and
//   palette index, tlast marks the final span of a byte, tuser marks the span
//   that completes the frame
// an accepted byte is held in the input register and decoded from there; its
//   spans are written into the span queue and offered from it on the master side
// one byte is taken every cycle while the span queue has room; a byte whose run
//   crosses a row end yields two spans and two transfers on the master side, so
//   the sustained byte rate is set by the single master channel
// a four-entry span queue sits between decode and the master side; decode
//   stalls when fewer than two entries are free, so a stalled receiver holds
//   back the slave side after at most a few bytes, with no loss
// reset clears position, token state and the frame-done flag; bytes arriving
//   after the frame is complete are accepted and dropped until reset
// ----------------------------------------------------------------------------
module rle_raster_span_decoder import rrsd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [BYTE_W-1:0]      i_s_tdata,   // stream_byte
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // span_row, span_column, span_length, color_index
    output logic                   o_m_tlast,   // last_span
    output logic                   o_m_tuser    // frame_done
);

    t_push            push;
    t_span            span;
    logic [CNT_W-1:0] fifo_count;

    rrsd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_fifo_count (fifo_count),
        .o_push       (push)
    );

    rrsd_span_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_count    (fifo_count),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_span     (span)
    );

    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, span.color, span.length, span.column, span.row};
    assign o_m_tlast = span.last;
    assign o_m_tuser = span.done;

endmodule

>>> sim/rle_raster_span_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_raster_span_decoder_test
// stream test of the run-length raster span decoder: directed literals, zero
// and full-size runs and an exact row end, then random literal and run
// sequences with and without idle cycles; every span is compared against a
// behavioral decoder kept in the bench
// ----------------------------------------------------------------------------
module rle_raster_span_decoder_test;
    import rrsd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int COL_LSB     = ROW_W;
    localparam int LEN_LSB     = ROW_W + COL_W;
    localparam int COLOR_LSB   = ROW_W + COL_W + LEN_W;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [BYTE_W-1:0]      i_s_tdata  = '0;   // stream_byte
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;         // span_row, span_column, span_length, color_index
    logic                   o_m_tlast;         // last_span
    logic                   o_m_tuser;         // frame_done

    logic [BYTE_W-1:0] stream_bytes[$];
    t_span             pending_spans[$];

    // decoder state as the bench sees it
    bit               want_index;
    bit [LEN_W-1:0]   run_len;
    bit [COL_W-1:0]   pix_col;
    bit [ROW_W-1:0]   pix_row;
    bit               frame_full;

    bit idle_on;
    int errors;
    int cycles;
    int bytes_taken;
    int spans_checked;
    int done_seen;

    rle_raster_span_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // lay a run of pixels into raster order, at most two spans
    function automatic void place_pixels(input int count, input logic [COLOR_W-1:0] color);
        int    left;
        int    room;
        int    take;
        int    made;
        int    next_col;
        t_span s;
        left = count;
        made = 0;
        while (left > 0 && made < 2 && !frame_full) begin
            room     = IMAGE_WIDTH - int'(pix_col);
            take     = (left < room) ? left : room;
            s.row    = pix_row;
            s.column = pix_col;
            s.length = LEN_W'(take);
            s.color  = color;
            s.last   = 1'b0;
            s.done   = 1'b0;
            left     -= take;
            made++;
            next_col = int'(pix_col) + take;
            if (next_col >= IMAGE_WIDTH) begin
                pix_col = '0;
                pix_row = pix_row + 1'b1;
                if (pix_row >= IMAGE_HEIGHT) begin
                    frame_full = 1'b1;
                    s.done     = 1'b1;
                end
            end else begin
                pix_col = COL_W'(next_col);
            end
            if (left == 0 || made == 2 || frame_full)
                s.last = 1'b1;
            pending_spans.push_back(s);
        end
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        if (frame_full)
            return;
        if (want_index) begin
            want_index = 1'b0;
            place_pixels(int'(run_len), b[COLOR_W-1:0]);
        end else if (b[7]) begin
            place_pixels(1, b[COLOR_W-1:0]);
        end else begin
            run_len    = b[LEN_W-1:0];
            want_index = 1'b1;
        end
    endfunction

    task automatic queue_run(input int count, input int color_byte);
        stream_bytes.push_back(BYTE_W'(count));
        stream_bytes.push_back(BYTE_W'(color_byte));
    endtask

    task automatic queue_random(input int n);
        int made;
        int pick;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                stream_bytes.push_back(BYTE_W'($urandom_range(128, 255)));
                made++;
            end else begin
                queue_run((pick < 38) ? 0 : $urandom_range(1, 127), $urandom_range(0, 255));
                made += 2;
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                decode_byte(i_s_tdata);
                bytes_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (stream_bytes.size() > 0 && !(idle_on && $urandom_range(0, 99) < 35)) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= stream_bytes.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= !(idle_on && $urandom_range(0, 99) < 35);
    end

    // span checker
    always @(posedge i_clk) begin : span_monitor
        t_span got;
        t_span want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.row    = o_m_tdata[0 +: ROW_W];
            got.column = o_m_tdata[COL_LSB +: COL_W];
            got.length = o_m_tdata[LEN_LSB +: LEN_W];
            got.color  = o_m_tdata[COLOR_LSB +: COLOR_W];
            got.last   = o_m_tlast;
            got.done   = o_m_tuser;
            if (pending_spans.size() == 0) begin
                errors++;
                $display("%0t: unexpected span row=%0d col=%0d len=%0d color=%0d last=%0b done=%0b",
                         $time, got.row, got.column, got.length, got.color, got.last, got.done);
            end else begin
                want = pending_spans.pop_front();
                spans_checked++;
                if (got.done)
                    done_seen++;
                if (got !== want) begin
                    errors++;
                    $display("%0t: span mismatch expected row=%0d col=%0d len=%0d color=%0d last=%0b done=%0b",
                             $time, want.row, want.column, want.length, want.color, want.last,
                             want.done);
                    $display("%0t:               actual row=%0d col=%0d len=%0d color=%0d last=%0b done=%0b",
                             $time, got.row, got.column, got.length, got.color, got.last,
                             got.done);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d spans outstanding", cycles,
                     pending_spans.size());
            $display("rle_raster_span_decoder verification failed");
            $finish;
        end
    end

    initial begin
        idle_on = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // literals at both ends, zero runs, index bytes with the top bit set
        stream_bytes.push_back(8'd128);
        stream_bytes.push_back(8'd255);
        queue_run(0, 8'h80);
        queue_run(0, 8'h00);
        queue_run(1, 8'h00);
        queue_run(127, 8'hff);
        queue_run(127, 8'h7f);
        queue_run(127, 8'h55);
        queue_run(127, 8'haa);
        queue_run(127, 8'h3c);
        // lands exactly on the row end
        queue_run(2, 8'h81);

        queue_random(200);
        while (stream_bytes.size() != 0) @(negedge i_clk);
        idle_on = 1'b0;
        queue_random(120);
        while (stream_bytes.size() != 0) @(negedge i_clk);
        idle_on = 1'b1;
        queue_random(80);

        while (stream_bytes.size() != 0 || i_s_tvalid) @(negedge i_clk);
        while (pending_spans.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("%0d stream bytes decoded into %0d spans, reaching row %0d", bytes_taken,
                 spans_checked, pix_row);
        $display("literals, zero and full runs and row splits under random stalls, %0d done",
                 done_seen);
        if (errors == 0)
            $display("rle_raster_span_decoder verification clean");
        else
            $display("rle_raster_span_decoder verification failed");
        $finish;
    end

endmodule
